// ===== rtl/core/fej_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 2D Euler flux Jacobian block.
// No dependencies; fej_front, fej_datapath, fej_serializer and the top level import this package.
`default_nettype none
package fej_pkg;

  // Fixed-point format of all data values.
  localparam int FRAC_BITS = 16;

  // Register index of the configuration port.
  localparam logic REG_HEAT_RATIO = 1'b0;

  // Reset value of gamma, 1.4 in unsigned Q2.16.
  localparam logic [17:0] HEAT_RESET = 18'd91750;

  localparam logic signed [95:0] RND_HALF = 96'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [95:0] I32_MAX  = 96'sd2147483647;
  localparam logic signed [95:0] I32_MIN  = -96'sd2147483648;

  // One face item as it travels from the front part to the datapath.
  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] e;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] g;
  } fej_item_t;

  typedef struct packed {
    logic      valid;
    fej_item_t item;
  } fej_issue_t;

  // One Jacobian row after clipping.
  typedef struct packed {
    logic [3:0][31:0] ent;
    logic             sat;
  } fej_row_t;

  typedef struct packed {
    logic               valid;
    fej_row_t [3:0]     row;
  } fej_mat_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } fej_clip_t;

  // Round an exact product to FRAC_BITS fraction bits, ties toward plus infinity.
  function automatic logic signed [95:0] fej_round(input logic signed [95:0] x);
    return (x + RND_HALF) >>> FRAC_BITS;
  endfunction

  // Saturate a wide value to 32-bit signed and flag clipping.
  function automatic fej_clip_t fej_clip(input logic signed [95:0] x);
    fej_clip_t c;
    c.sat = 1'b0;
    c.val = x[31:0];
    if (x > I32_MAX) begin
      c.sat = 1'b1;
      c.val = 32'h7FFF_FFFF;
    end else if (x < I32_MIN) begin
      c.sat = 1'b1;
      c.val = 32'h8000_0000;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fej_front.sv =====
// Front part: accepts face items into a two-entry queue and issues them to the datapath.
// Depends on fej_pkg. A gap counter spaces successive issues apart.
`default_nettype none
module fej_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire fej_pkg::fej_item_t item_in,
  output logic                    busy,
  output fej_pkg::fej_issue_t     issue
);
  import fej_pkg::*;

  fej_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] gap_r, gap_nxt;
  logic       push, pop;

  // Queue control: full queue holds off the issuer of commands.
  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign pop  = (cnt_r != 2'd0) && (gap_r == 2'd0);

  assign issue.valid = pop;
  assign issue.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
    // Space issues apart with the gap counter so each matrix owns the output for its rows.
    if (pop) begin
      gap_nxt = 2'd3;
    end else if (gap_r != 2'd0) begin
      gap_nxt = gap_r - 2'd1;
    end else begin
      gap_nxt = gap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      gap_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      gap_r    <= gap_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fej_datapath.sv =====
// Back part: six-stage pipeline that forms the 4x4 flux Jacobian of one item.
// Depends on fej_pkg. Products are formed in stages 1, 3, 5 and 6, and every stage is registered.
`default_nettype none
module fej_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fej_pkg::fej_issue_t issue,
  output fej_pkg::fej_mat_t        mat
);
  import fej_pkg::*;

  localparam logic signed [18:0] ONE = 19'sd1 <<< FRAC_BITS;

  // Stage valid bits.
  logic [6:1] vld_r;

  // Stage 1 values.
  logic signed [31:0] i_u, i_v, i_e;
  logic signed [17:0] i_nx, i_ny;
  logic signed [18:0] i_g, i_a2, i_a3;
  logic signed [64:0] s1_uu_r, s1_vv_r;
  logic signed [50:0] s1_nxu_r, s1_nyv_r, s1_nyu_r, s1_nxv_r;
  logic signed [51:0] s1_ge_r, s1_a2u_r, s1_a2v_r;
  logic signed [37:0] s1_a3nx_r, s1_a2nx_r, s1_a3ny_r, s1_a2ny_r;
  logic signed [18:0] s1_h_r, s1_g_r;
  logic signed [31:0] s1_u_r, s1_v_r;
  logic signed [17:0] s1_nx_r, s1_ny_r;

  // Stage 2 values.
  logic signed [48:0] s2_uu, s2_vv;
  logic signed [34:0] s2_nxu, s2_nyv;
  logic signed [49:0] s2_s_r;
  logic signed [35:0] s2_vn_r, s2_ge_r, s2_a2u_r, s2_a2v_r;
  logic signed [34:0] s2_nyu_r, s2_nxv_r;
  logic signed [21:0] s2_a3nx_r, s2_a2nx_r, s2_a3ny_r, s2_a2ny_r;
  logic signed [18:0] s2_h_r, s2_g_r;
  logic signed [31:0] s2_u_r, s2_v_r;
  logic signed [17:0] s2_nx_r, s2_ny_r;

  // Stage 3 values.
  logic signed [69:0] s3_phip_r;
  logic signed [54:0] s3_a3nxu_r, s3_a2nxv_r, s3_a2nyu_r, s3_a3nyv_r;
  logic signed [68:0] s3_uvn_r, s3_vvn_r;
  logic signed [72:0] s3_a2uvn_r, s3_a2vvn_r;
  logic signed [55:0] s3_gvn_r;
  logic signed [35:0] s3_vn_r, s3_ge_r;
  logic signed [34:0] s3_nyu_r, s3_nxv_r;
  logic signed [21:0] s3_a2nx_r, s3_a2ny_r;
  logic signed [17:0] s3_nx_r, s3_ny_r;

  // Stage 4 values.
  logic signed [53:0] s4_phi;
  logic signed [53:0] s4_phi_r;
  logic signed [54:0] s4_a1_r;
  logic signed [38:0] s4_a3nxu_r, s4_a2nxv_r, s4_a2nyu_r, s4_a3nyv_r;
  logic signed [52:0] s4_uvn_r, s4_vvn_r;
  logic signed [56:0] s4_a2uvn_r, s4_a2vvn_r;
  logic signed [39:0] s4_gvn_r;
  logic signed [35:0] s4_vn_r;
  logic signed [34:0] s4_nyu_r, s4_nxv_r;
  logic signed [21:0] s4_a2nx_r, s4_a2ny_r;
  logic signed [17:0] s4_nx_r, s4_ny_r;

  // Stage 5 values.
  logic signed [72:0] s5_nxphi_r, s5_nyphi_r;
  logic signed [73:0] s5_nxa1_r, s5_nya1_r;
  logic signed [55:0] s5_d_r;
  logic signed [39:0] s5_m11_r, s5_m12_r, s5_m21_r, s5_m22_r;
  logic signed [35:0] s5_vn_r;
  logic signed [52:0] s5_uvn_r, s5_vvn_r;
  logic signed [56:0] s5_a2uvn_r, s5_a2vvn_r;
  logic signed [39:0] s5_gvn_r;
  logic signed [21:0] s5_a2nx_r, s5_a2ny_r;
  logic signed [17:0] s5_nx_r, s5_ny_r;

  // Stage 6 values.
  logic signed [56:0] s6_nxphi, s6_nyphi;
  logic signed [57:0] s6_nxa1, s6_nya1;
  logic signed [64:0] s6_vndl_r;
  logic signed [63:0] s6_vndh_r;
  logic signed [57:0] s6_m10_r, s6_m20_r;
  logic signed [58:0] s6_m31_r, s6_m32_r;
  logic signed [39:0] s6_m11_r, s6_m12_r, s6_m21_r, s6_m22_r;
  logic signed [39:0] s6_gvn_r;
  logic signed [21:0] s6_a2nx_r, s6_a2ny_r;
  logic signed [17:0] s6_nx_r, s6_ny_r;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:1], issue.valid};
    end
  end

  // Stage 1: first-level products of the raw inputs.
  always_comb begin
    i_u  = $signed(issue.item.u);
    i_v  = $signed(issue.item.v);
    i_e  = $signed(issue.item.e);
    i_nx = $signed(issue.item.nx);
    i_ny = $signed(issue.item.ny);
    i_g  = $signed({1'b0, issue.item.g});
    i_a2 = i_g - ONE;
    i_a3 = i_g - (ONE <<< 1);
  end

  always_ff @(posedge clk) begin
    s1_uu_r   <= i_u * i_u;
    s1_vv_r   <= i_v * i_v;
    s1_nxu_r  <= i_nx * i_u;
    s1_nyv_r  <= i_ny * i_v;
    s1_nyu_r  <= i_ny * i_u;
    s1_nxv_r  <= i_nx * i_v;
    s1_ge_r   <= i_g * i_e;
    s1_a2u_r  <= i_a2 * i_u;
    s1_a2v_r  <= i_a2 * i_v;
    s1_a3nx_r <= i_a3 * i_nx;
    s1_a2nx_r <= i_a2 * i_nx;
    s1_a3ny_r <= i_a3 * i_ny;
    s1_a2ny_r <= i_a2 * i_ny;
    s1_h_r    <= 19'(fej_round(96'(i_a2) <<< (FRAC_BITS - 1)));
    s1_g_r    <= i_g;
    s1_u_r    <= i_u;
    s1_v_r    <= i_v;
    s1_nx_r   <= i_nx;
    s1_ny_r   <= i_ny;
  end

  // Stage 2: rounding, kinetic sum and normal velocity.
  always_comb begin
    s2_uu  = 49'(fej_round(96'(s1_uu_r)));
    s2_vv  = 49'(fej_round(96'(s1_vv_r)));
    s2_nxu = 35'(fej_round(96'(s1_nxu_r)));
    s2_nyv = 35'(fej_round(96'(s1_nyv_r)));
  end

  always_ff @(posedge clk) begin
    s2_s_r    <= 50'(s2_uu) + 50'(s2_vv);
    s2_vn_r   <= 36'(s2_nxu) + 36'(s2_nyv);
    s2_ge_r   <= 36'(fej_round(96'(s1_ge_r)));
    s2_a2u_r  <= 36'(fej_round(96'(s1_a2u_r)));
    s2_a2v_r  <= 36'(fej_round(96'(s1_a2v_r)));
    s2_nyu_r  <= 35'(fej_round(96'(s1_nyu_r)));
    s2_nxv_r  <= 35'(fej_round(96'(s1_nxv_r)));
    s2_a3nx_r <= 22'(fej_round(96'(s1_a3nx_r)));
    s2_a2nx_r <= 22'(fej_round(96'(s1_a2nx_r)));
    s2_a3ny_r <= 22'(fej_round(96'(s1_a3ny_r)));
    s2_a2ny_r <= 22'(fej_round(96'(s1_a2ny_r)));
    s2_h_r    <= s1_h_r;
    s2_g_r    <= s1_g_r;
    s2_u_r    <= s1_u_r;
    s2_v_r    <= s1_v_r;
    s2_nx_r   <= s1_nx_r;
    s2_ny_r   <= s1_ny_r;
  end

  // Stage 3: second-level products.
  always_ff @(posedge clk) begin
    s3_phip_r  <= s2_h_r * s2_s_r;
    s3_a3nxu_r <= s2_a3nx_r * s2_u_r;
    s3_a2nxv_r <= s2_a2nx_r * s2_v_r;
    s3_a2nyu_r <= s2_a2ny_r * s2_u_r;
    s3_a3nyv_r <= s2_a3ny_r * s2_v_r;
    s3_uvn_r   <= s2_u_r * s2_vn_r;
    s3_vvn_r   <= s2_v_r * s2_vn_r;
    s3_a2uvn_r <= s2_a2u_r * s2_vn_r;
    s3_a2vvn_r <= s2_a2v_r * s2_vn_r;
    s3_gvn_r   <= s2_g_r * s2_vn_r;
    s3_vn_r    <= s2_vn_r;
    s3_ge_r    <= s2_ge_r;
    s3_nyu_r   <= s2_nyu_r;
    s3_nxv_r   <= s2_nxv_r;
    s3_a2nx_r  <= s2_a2nx_r;
    s3_a2ny_r  <= s2_a2ny_r;
    s3_nx_r    <= s2_nx_r;
    s3_ny_r    <= s2_ny_r;
  end

  // Stage 4: rounding, phi and a1.
  assign s4_phi = 54'(fej_round(96'(s3_phip_r)));

  always_ff @(posedge clk) begin
    s4_phi_r   <= s4_phi;
    s4_a1_r    <= 55'(s3_ge_r) - 55'(s4_phi);
    s4_a3nxu_r <= 39'(fej_round(96'(s3_a3nxu_r)));
    s4_a2nxv_r <= 39'(fej_round(96'(s3_a2nxv_r)));
    s4_a2nyu_r <= 39'(fej_round(96'(s3_a2nyu_r)));
    s4_a3nyv_r <= 39'(fej_round(96'(s3_a3nyv_r)));
    s4_uvn_r   <= 53'(fej_round(96'(s3_uvn_r)));
    s4_vvn_r   <= 53'(fej_round(96'(s3_vvn_r)));
    s4_a2uvn_r <= 57'(fej_round(96'(s3_a2uvn_r)));
    s4_a2vvn_r <= 57'(fej_round(96'(s3_a2vvn_r)));
    s4_gvn_r   <= 40'(fej_round(96'(s3_gvn_r)));
    s4_vn_r    <= s3_vn_r;
    s4_nyu_r   <= s3_nyu_r;
    s4_nxv_r   <= s3_nxv_r;
    s4_a2nx_r  <= s3_a2nx_r;
    s4_a2ny_r  <= s3_a2ny_r;
    s4_nx_r    <= s3_nx_r;
    s4_ny_r    <= s3_ny_r;
  end

  // Stage 5: products with phi and a1, and the velocity-only entries.
  always_ff @(posedge clk) begin
    s5_nxphi_r <= s4_nx_r * s4_phi_r;
    s5_nyphi_r <= s4_ny_r * s4_phi_r;
    s5_nxa1_r  <= s4_nx_r * s4_a1_r;
    s5_nya1_r  <= s4_ny_r * s4_a1_r;
    s5_d_r     <= 56'(s4_phi_r) - 56'(s4_a1_r);
    s5_m11_r   <= 40'(s4_vn_r) - 40'(s4_a3nxu_r);
    s5_m12_r   <= 40'(s4_nyu_r) - 40'(s4_a2nxv_r);
    s5_m21_r   <= 40'(s4_nxv_r) - 40'(s4_a2nyu_r);
    s5_m22_r   <= 40'(s4_vn_r) - 40'(s4_a3nyv_r);
    s5_vn_r    <= s4_vn_r;
    s5_uvn_r   <= s4_uvn_r;
    s5_vvn_r   <= s4_vvn_r;
    s5_a2uvn_r <= s4_a2uvn_r;
    s5_a2vvn_r <= s4_a2vvn_r;
    s5_gvn_r   <= s4_gvn_r;
    s5_a2nx_r  <= s4_a2nx_r;
    s5_a2ny_r  <= s4_a2ny_r;
    s5_nx_r    <= s4_nx_r;
    s5_ny_r    <= s4_ny_r;
  end

  // Stage 6: energy-row product and the remaining differences.
  always_comb begin
    s6_nxphi = 57'(fej_round(96'(s5_nxphi_r)));
    s6_nyphi = 57'(fej_round(96'(s5_nyphi_r)));
    s6_nxa1  = 58'(fej_round(96'(s5_nxa1_r)));
    s6_nya1  = 58'(fej_round(96'(s5_nya1_r)));
  end

  // The energy-row product is split over the low and high halves of phi - a1
  // so that each multiplier stays near 32 by 32 bits.
  always_ff @(posedge clk) begin
    s6_vndl_r <= s5_vn_r * $signed({1'b0, s5_d_r[27:0]});
    s6_vndh_r <= s5_vn_r * $signed(s5_d_r[55:28]);
    s6_m10_r  <= 58'(s6_nxphi) - 58'(s5_uvn_r);
    s6_m20_r  <= 58'(s6_nyphi) - 58'(s5_vvn_r);
    s6_m31_r  <= 59'(s6_nxa1) - 59'(s5_a2uvn_r);
    s6_m32_r  <= 59'(s6_nya1) - 59'(s5_a2vvn_r);
    s6_m11_r  <= s5_m11_r;
    s6_m12_r  <= s5_m12_r;
    s6_m21_r  <= s5_m21_r;
    s6_m22_r  <= s5_m22_r;
    s6_gvn_r  <= s5_gvn_r;
    s6_a2nx_r <= s5_a2nx_r;
    s6_a2ny_r <= s5_a2ny_r;
    s6_nx_r   <= s5_nx_r;
    s6_ny_r   <= s5_ny_r;
  end

  // Output: clip every entry to 32 bits and gather the per-row flags.
  fej_clip_t c [4][4];

  always_comb begin
    c[0][0] = fej_clip(96'sd0);
    c[0][1] = fej_clip(96'(s6_nx_r));
    c[0][2] = fej_clip(96'(s6_ny_r));
    c[0][3] = fej_clip(96'sd0);
    c[1][0] = fej_clip(96'(s6_m10_r));
    c[1][1] = fej_clip(96'(s6_m11_r));
    c[1][2] = fej_clip(96'(s6_m12_r));
    c[1][3] = fej_clip(96'(s6_a2nx_r));
    c[2][0] = fej_clip(96'(s6_m20_r));
    c[2][1] = fej_clip(96'(s6_m21_r));
    c[2][2] = fej_clip(96'(s6_m22_r));
    c[2][3] = fej_clip(96'(s6_a2ny_r));
    c[3][0] = fej_clip(fej_round((96'(s6_vndh_r) <<< 28) + 96'(s6_vndl_r)));
    c[3][1] = fej_clip(96'(s6_m31_r));
    c[3][2] = fej_clip(96'(s6_m32_r));
    c[3][3] = fej_clip(96'(s6_gvn_r));
    mat.valid = vld_r[6];
    for (int r = 0; r < 4; r++) begin
      mat.row[r].sat = c[r][0].sat | c[r][1].sat | c[r][2].sat | c[r][3].sat;
      for (int k = 0; k < 4; k++) begin
        mat.row[r].ent[k] = c[r][k].val;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fej_serializer.sv =====
// Output stage: holds one finished matrix and sends its four rows on consecutive cycles.
// Depends on fej_pkg. A new matrix arrives no sooner than the last row of the previous one.
`default_nettype none
module fej_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fej_pkg::fej_mat_t mat,
  output logic                   out_valid,
  output logic [1:0]             out_row_index,
  output logic [31:0]            out_entry_0,
  output logic [31:0]            out_entry_1,
  output logic [31:0]            out_entry_2,
  output logic [31:0]            out_entry_3,
  output logic                   out_saturated,
  output logic                   out_last_row
);
  import fej_pkg::*;

  fej_row_t [3:0] rows_r;
  logic [1:0]     row_r, row_nxt;
  logic           act_r, act_nxt;

  // Row sequencing.
  always_comb begin
    row_nxt = row_r;
    act_nxt = act_r;
    if (mat.valid) begin
      row_nxt = 2'd0;
      act_nxt = 1'b1;
    end else if (act_r) begin
      row_nxt = row_r + 2'd1;
      act_nxt = (row_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 2'd0;
      act_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      act_r <= act_nxt;
    end
  end

  // Matrix holding register.
  always_ff @(posedge clk) begin
    if (mat.valid) begin
      rows_r <= mat.row;
    end
  end

  // Result ports.
  assign out_valid     = act_r;
  assign out_row_index = row_r;
  assign out_entry_0   = rows_r[row_r].ent[0];
  assign out_entry_1   = rows_r[row_r].ent[1];
  assign out_entry_2   = rows_r[row_r].ent[2];
  assign out_entry_3   = rows_r[row_r].ent[3];
  assign out_saturated = rows_r[row_r].sat;
  assign out_last_row  = (row_r == 2'd3);

endmodule
`default_nettype wire

// ===== rtl/core/euler_2d_flux_jacobian_top.sv =====
// An accepted item passes the queue, the datapath stages and the serializer row register before its rows appear.
// Issues are spaced apart because the four row results of each item share one result channel.
// A two-entry queue takes items while the datapath works; busy rises only when it is full.
// The result strobe cannot be held off. Reset is synchronous, active low, and sets gamma to 1.4.
// Depends on fej_pkg, fej_front, fej_datapath and fej_serializer.
`default_nettype none
module euler_2d_flux_jacobian_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_velocity_x,
  input  wire logic [31:0] in_velocity_y,
  input  wire logic [31:0] in_total_energy,
  input  wire logic [17:0] in_normal_x,
  input  wire logic [17:0] in_normal_y,
  output logic             out_valid,
  output logic [1:0]       out_row_index,
  output logic [31:0]      out_entry_0,
  output logic [31:0]      out_entry_1,
  output logic [31:0]      out_entry_2,
  output logic [31:0]      out_entry_3,
  output logic             out_saturated,
  output logic             out_last_row,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fej_pkg::*;

  logic [17:0] heat_ratio_r;
  fej_item_t   item;
  fej_issue_t  issue;
  fej_mat_t    mat;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_ratio_r <= HEAT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEAT_RATIO)) begin
      heat_ratio_r <= pwdata[17:0];
    end
  end

  assign prdata = (paddr[2] == REG_HEAT_RATIO) ? {14'd0, heat_ratio_r} : 32'd0;

  // Item as captured at acceptance, gamma included.
  always_comb begin
    item.u  = in_velocity_x;
    item.v  = in_velocity_y;
    item.e  = in_total_energy;
    item.nx = in_normal_x;
    item.ny = in_normal_y;
    item.g  = heat_ratio_r;
  end

  fej_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item_in (item),
    .busy    (busy),
    .issue   (issue)
  );

  fej_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .mat   (mat)
  );

  fej_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .mat           (mat),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_entry_0   (out_entry_0),
    .out_entry_1   (out_entry_1),
    .out_entry_2   (out_entry_2),
    .out_entry_3   (out_entry_3),
    .out_saturated (out_saturated),
    .out_last_row  (out_last_row)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fej_checker.sv =====
// Port-level checks of the flux Jacobian block, bound to the top level.
// Depends on euler_2d_flux_jacobian_top for its port names only.
`default_nettype none
module fej_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic [1:0]  out_row_index,
  input wire logic [31:0] out_entry_0,
  input wire logic [31:0] out_entry_3,
  input wire logic        out_saturated,
  input wire logic        out_last_row,
  input wire logic        pready
);

  // Rows of one item come on consecutive cycles.
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_index != 2'd3) |=>
      out_valid && (out_row_index == 2'($past(out_row_index) + 2'd1)))
    else $error("row sequence broken");

  // The last flag marks row 3 only.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd3)))
    else $error("last flag wrong");

  // Row 0 carries zero corners and never clips.
  a_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_index == 2'd0) |->
      (out_entry_0 == 32'd0) && (out_entry_3 == 32'd0) && !out_saturated)
    else $error("row 0 malformed");

  // An item's results start at row 0.
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_row_index == 2'd0))
    else $error("results do not start at row 0");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind euler_2d_flux_jacobian_top fej_checker u_fej_checker (.*);
`default_nettype wire
